// File: rtl/smsh_pkg.sv
// Shared constants and types of the seeded splitmix sequence hasher.
package smsh_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

    localparam int SHIFT_1  = 30;
    localparam int SHIFT_2  = 27;
    localparam int SHIFT_3  = 31;
    localparam int COMB_SHL = 12;
    localparam int COMB_SHR = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // partial-product passes of a 64x64 low-half multiply
    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [63:0] element;
        logic        first;
        logic        last;
        logic        emit;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/smsh_ifs.sv
// Channel interfaces: input words, result words, seed writes.
interface smsh_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] element;
    logic        first;
    logic        last;
    modport source (output valid, output mode, output element, output first, output last,
                    input ready);
    modport sink   (input valid, input mode, input element, input first, input last,
                    output ready);
endinterface

interface smsh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface smsh_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_seed;
    modport source (output valid, output hash_seed, input ready);
    modport sink   (input valid, input hash_seed, output ready);
endinterface

// File: rtl/smsh_front.sv
// Front end: input handshake and classification of each word.
module smsh_front
    import smsh_pkg::*;
(
    smsh_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output t_item            o_item
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_item.mode    = i_in.mode;
        o_item.element = i_in.element;
        o_item.first   = i_in.first;
        o_item.last    = i_in.last;
        // a single hash always yields a result, a sequence word only on last
        o_item.emit    = !i_in.mode || i_in.last;
    end

endmodule

// File: rtl/smsh_fifo.sv
// Short queue of classified words between front end and hash engine.
module smsh_fifo
    import smsh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/smsh_core.sv
// Hash engine: seeded splitmix64 finalizer on a shared 32x32 multiplier, sequence combine.
module smsh_core
    import smsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_seed,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    smsh_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MIX,
        S_MUL_B,
        S_FIN,
        S_COMB,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [1:0]  r_step;
    t_item       r_item;
    logic [63:0] r_z;
    logic [63:0] r_p;
    logic [63:0] r_t;
    logic [63:0] r_base;
    logic [63:0] r_run;
    logic [63:0] r_res;
    logic        r_out_valid;
    logic [63:0] r_out_hash;

    logic [63:0] n_z0;
    logic [63:0] n_h;
    logic [63:0] n_comb;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_c;
    logic [63:0] prod;
    logic        out_free;

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;
    assign out_free    = !r_out_valid || o_out.ready;

    assign n_z0   = i_item.element + GOLDEN_GAMMA + i_seed;
    assign n_h    = r_p ^ (r_p >> SHIFT_3);
    assign n_comb = r_base ^ (r_t + (r_base << COMB_SHL) + (r_base >> COMB_SHR));

    // low 64 bits of z*C: lo*lo, then the two cross terms into the upper half
    assign mul_c = (r_state == S_MUL_B) ? MIX_MUL_B : MIX_MUL_A;
    assign mul_x = (r_step == STEP_HL) ? r_z[63:32] : r_z[31:0];
    assign mul_y = (r_step == STEP_LH) ? mul_c[63:32] : mul_c[31:0];
    assign prod  = 64'(mul_x) * 64'(mul_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_LL;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_item;
                        r_z     <= n_z0 ^ (n_z0 >> SHIFT_1);
                        r_step  <= STEP_LL;
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A, S_MUL_B: begin
                    case (r_step)
                        STEP_LL: begin
                            r_p    <= prod;
                            r_step <= STEP_LH;
                        end
                        STEP_LH: begin
                            r_p[63:32] <= r_p[63:32] + prod[31:0];
                            r_step     <= STEP_HL;
                        end
                        STEP_HL: begin
                            r_p[63:32] <= r_p[63:32] + prod[31:0];
                            r_step     <= STEP_LL;
                            r_state    <= (r_state == S_MUL_A) ? S_MIX : S_FIN;
                        end
                        default: r_step <= STEP_LL;
                    endcase
                end
                S_MIX: begin
                    r_z     <= r_p ^ (r_p >> SHIFT_2);
                    r_step  <= STEP_LL;
                    r_state <= S_MUL_B;
                end
                S_FIN: begin
                    if (!r_item.mode) begin
                        r_res   <= n_h;
                        r_state <= S_OUT;
                    end else begin
                        r_t     <= n_h + GOLDEN_GAMMA;
                        r_base  <= r_item.first ? i_seed : r_run;
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    r_run   <= n_comb;
                    r_res   <= n_comb;
                    r_state <= r_item.emit ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_hash  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/seeded_splitmix_sequence_hasher_top.sv
// Top level of the seeded splitmix64 hasher with sequence combine.
//
// Channels: i_in takes words {mode, element, first, last}; o_out returns
// hash_value words; i_cfg writes the 64-bit hash_seed (always ready, write
// it only while the block is idle).
// mode 0 hashes one element and returns one word. mode 1 folds the element
// into the running sequence hash (restarted from the seed on first) and
// returns the running hash only on last.
// An accepted word is written into the queue and reaches the engine from
// there when the engine is idle; the result leaves through the output register.
// The engine works on one word at a time and takes the next only when idle;
// its single 32x32 multiplier builds each of the two 64-bit finalizer
// products in three passes.
// A 4-word queue lets the input keep accepting while the engine works.
// Reset (synchronous, active low) clears the seed, the running hash, the
// queue and the output valid flag.
// When the receiver stalls, the result holds in the output register; the
// engine finishes its next word and then waits, and the queue fills before
// i_in.ready drops.
module seeded_splitmix_sequence_hasher_top
    import smsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    smsh_in_if.sink     i_in,
    smsh_cfg_if.sink    i_cfg,
    smsh_out_if.source  o_out
);

    logic [63:0] r_seed;
    logic        push;
    logic        pop;
    t_item       push_item;
    t_item       head_item;
    t_q_stat     q_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg.valid) begin
            r_seed <= i_cfg.hash_seed;
        end
    end

    smsh_front u_front (
        .i_in    (i_in),
        .i_full  (q_stat.full),
        .o_push  (push),
        .o_item  (push_item)
    );

    smsh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    smsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .i_empty (q_stat.empty),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("queue written while full");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && !pop) |=> !push)
        else $error("word taken with no queue room");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && q_stat.empty))
        else $error("output or queue not cleared by reset");

endmodule
